// ----- rtl/integer_token_parser_macros.svh -----
// Assertion macros for the integer token parser.
// Included by the top level; no other dependencies.
`ifndef INTEGER_TOKEN_PARSER_MACROS_SVH
`define INTEGER_TOKEN_PARSER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked at every rising clock edge out of reset.
`define ITP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("integer_token_parser: same-cycle check failed");

// Next-cycle implication.
`define ITP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("integer_token_parser: next-cycle check failed");

`else

`define ITP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ITP_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/itp_pkg.sv -----
// Shared types, character codes and helper functions for the integer token parser.
// No dependencies.
`default_nettype none

package itp_pkg;

  localparam int unsigned AccW = 64;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_LC_X  = 8'h78;
  localparam logic [7:0] CH_UC_X  = 8'h58;
  localparam logic [7:0] CH_LC_B  = 8'h62;
  localparam logic [7:0] CH_UC_B  = 8'h42;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_F  = 8'h66;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_F  = 8'h46;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_INVALID  = 3'd2,
    ST_OVERFLOW = 3'd3,
    ST_RANGE    = 3'd4,
    ST_NEGUNS   = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    BASE_DEC = 2'd0,
    BASE_HEX = 2'd1,
    BASE_BIN = 2'd2,
    BASE_OCT = 2'd3
  } base_e;

  typedef enum logic [3:0] {
    STG_SIGN   = 4'b0001,
    STG_FIRST  = 4'b0010,
    STG_ZERO   = 4'b0100,
    STG_DIGITS = 4'b1000
  } stage_e;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } digit_t;

  // Token as it stands after its final character.
  typedef struct packed {
    logic [AccW-1:0] acc;
    logic            neg;
    status_e         err;
    logic            seen;
  } itp_tok_t;

  function automatic digit_t digit_value(input logic [7:0] c);
    digit_t d;
    d.ok  = 1'b0;
    d.val = 4'd0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d.ok  = 1'b1;
      d.val = 4'(c - CH_ZERO);
    end else if (c >= CH_LC_A && c <= CH_LC_F) begin
      d.ok  = 1'b1;
      d.val = 4'(c - CH_LC_A) + 4'd10;
    end else if (c >= CH_UC_A && c <= CH_UC_F) begin
      d.ok  = 1'b1;
      d.val = 4'(c - CH_UC_A) + 4'd10;
    end
    return d;
  endfunction

  function automatic logic [AccW-1:0] type_max(input logic [2:0] vtype);
    logic [AccW-1:0] m;
    unique case (vtype)
      3'd0:    m = 64'h0000_0000_0000_007F;
      3'd1:    m = 64'h0000_0000_0000_00FF;
      3'd2:    m = 64'h0000_0000_0000_7FFF;
      3'd3:    m = 64'h0000_0000_0000_FFFF;
      3'd4:    m = 64'h0000_0000_7FFF_FFFF;
      3'd5:    m = 64'h0000_0000_FFFF_FFFF;
      3'd6:    m = 64'h7FFF_FFFF_FFFF_FFFF;
      default: m = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return m;
  endfunction

  function automatic logic [AccW-1:0] type_mask(input logic [1:0] wsel);
    logic [AccW-1:0] m;
    unique case (wsel)
      2'd0:    m = 64'h0000_0000_0000_00FF;
      2'd1:    m = 64'h0000_0000_0000_FFFF;
      2'd2:    m = 64'h0000_0000_FFFF_FFFF;
      default: m = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/itp_scan.sv -----
// Character scanner: sign, prefix and digit accumulation for one token.
// Depends on itp_pkg.
`default_nettype none

module itp_scan (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            step_i,
  input  wire logic [7:0]      ch_i,
  input  wire logic [2:0]      vtype_i,
  input  wire logic            last_i,
  output itp_pkg::itp_tok_t    tok_o
);

  logic [itp_pkg::AccW-1:0] acc_q, acc_d;
  itp_pkg::base_e           base_q, base_d;
  logic                     neg_q, neg_d;
  itp_pkg::status_e         err_q, err_d;
  itp_pkg::stage_e          stage_q, stage_d;
  logic                     seen_q, seen_d;

  logic                     dig_en;
  itp_pkg::base_e           dig_base;
  itp_pkg::digit_t          dv;
  logic [itp_pkg::AccW+3:0] prod;
  logic [itp_pkg::AccW+4:0] sum;
  logic                     too_big;
  logic                     is_signed;
  logic                     is_octal;

  assign is_signed = ~vtype_i[0];
  assign is_octal  = (ch_i >= itp_pkg::CH_ZERO) && (ch_i <= itp_pkg::CH_SEVEN);
  assign dv        = itp_pkg::digit_value(ch_i);

  // Multiply by the radix with shifts, plus one add for decimal.
  always_comb begin
    unique case (dig_base)
      itp_pkg::BASE_DEC: begin
        prod    = ({4'd0, acc_q} << 3) + ({4'd0, acc_q} << 1);
        too_big = (dv.val > 4'd9);
      end
      itp_pkg::BASE_HEX: begin
        prod    = {4'd0, acc_q} << 4;
        too_big = 1'b0;
      end
      itp_pkg::BASE_BIN: begin
        prod    = {4'd0, acc_q} << 1;
        too_big = (dv.val > 4'd1);
      end
      default: begin
        prod    = {4'd0, acc_q} << 3;
        too_big = (dv.val > 4'd7);
      end
    endcase
  end

  assign sum = {1'b0, prod} + (itp_pkg::AccW+5)'(dv.val);

  always_comb begin
    acc_d    = acc_q;
    base_d   = base_q;
    neg_d    = neg_q;
    err_d    = err_q;
    stage_d  = stage_q;
    seen_d   = seen_q;
    dig_en   = 1'b0;
    dig_base = base_q;

    if (err_q == itp_pkg::ST_OK) begin
      unique case (stage_q)
        itp_pkg::STG_SIGN, itp_pkg::STG_FIRST: begin
          priority if (stage_q == itp_pkg::STG_SIGN && ch_i == itp_pkg::CH_MINUS) begin
            if (is_signed) begin
              neg_d   = 1'b1;
              stage_d = itp_pkg::STG_FIRST;
            end else begin
              err_d = itp_pkg::ST_NEGUNS;
            end
          end else if (stage_q == itp_pkg::STG_SIGN && ch_i == itp_pkg::CH_PLUS) begin
            stage_d = itp_pkg::STG_FIRST;
          end else if (ch_i == itp_pkg::CH_ZERO) begin
            seen_d  = 1'b1;
            stage_d = itp_pkg::STG_ZERO;
          end else begin
            base_d   = itp_pkg::BASE_DEC;
            dig_base = itp_pkg::BASE_DEC;
            stage_d  = itp_pkg::STG_DIGITS;
            dig_en   = 1'b1;
          end
        end
        itp_pkg::STG_ZERO: begin
          stage_d = itp_pkg::STG_DIGITS;
          priority if (ch_i == itp_pkg::CH_LC_X || ch_i == itp_pkg::CH_UC_X) begin
            base_d = itp_pkg::BASE_HEX;
            seen_d = 1'b0;
          end else if (ch_i == itp_pkg::CH_LC_B || ch_i == itp_pkg::CH_UC_B) begin
            base_d = itp_pkg::BASE_BIN;
            seen_d = 1'b0;
          end else if (is_octal) begin
            base_d   = itp_pkg::BASE_OCT;
            dig_base = itp_pkg::BASE_OCT;
            dig_en   = 1'b1;
          end else begin
            base_d   = itp_pkg::BASE_DEC;
            dig_base = itp_pkg::BASE_DEC;
            dig_en   = 1'b1;
          end
        end
        default: begin
          dig_en = 1'b1;
        end
      endcase

      if (dig_en) begin
        priority if (!dv.ok || too_big) begin
          err_d = itp_pkg::ST_INVALID;
        end else if (sum[itp_pkg::AccW+4:itp_pkg::AccW] != '0) begin
          err_d = itp_pkg::ST_OVERFLOW;
        end else begin
          acc_d  = sum[itp_pkg::AccW-1:0];
          seen_d = 1'b1;
        end
      end
    end
  end

  // The final character's update goes out on tok_o; the state itself restarts.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      base_q  <= itp_pkg::BASE_DEC;
      neg_q   <= 1'b0;
      err_q   <= itp_pkg::ST_OK;
      stage_q <= itp_pkg::STG_SIGN;
      seen_q  <= 1'b0;
    end else if (step_i) begin
      if (last_i) begin
        acc_q   <= '0;
        base_q  <= itp_pkg::BASE_DEC;
        neg_q   <= 1'b0;
        err_q   <= itp_pkg::ST_OK;
        stage_q <= itp_pkg::STG_SIGN;
        seen_q  <= 1'b0;
      end else begin
        acc_q   <= acc_d;
        base_q  <= base_d;
        neg_q   <= neg_d;
        err_q   <= err_d;
        stage_q <= stage_d;
        seen_q  <= seen_d;
      end
    end
  end

  assign tok_o.acc  = acc_d;
  assign tok_o.neg  = neg_d;
  assign tok_o.err  = err_d;
  assign tok_o.seen = seen_d;

endmodule

`default_nettype wire

// ----- rtl/itp_finish.sv -----
// Final range check, negation and width masking of a finished token.
// Depends on itp_pkg.
`default_nettype none

module itp_finish (
  input  wire itp_pkg::itp_tok_t     tok_i,
  input  wire logic [2:0]            vtype_i,
  output logic [itp_pkg::AccW-1:0]   value_o,
  output itp_pkg::status_e           status_o
);

  logic                   neg;
  logic [itp_pkg::AccW:0] limit;
  logic [itp_pkg::AccW-1:0] signed_val;

  // A sign is honored only if the type at the final character is signed.
  assign neg        = tok_i.neg & ~vtype_i[0];
  assign limit      = {1'b0, itp_pkg::type_max(vtype_i)} + (itp_pkg::AccW+1)'(neg);
  assign signed_val = neg ? (~tok_i.acc + 64'd1) : tok_i.acc;

  always_comb begin
    value_o  = '0;
    status_o = tok_i.err;
    if (tok_i.err == itp_pkg::ST_OK) begin
      if (!tok_i.seen) begin
        status_o = itp_pkg::ST_EMPTY;
      end else if ({1'b0, tok_i.acc} > limit) begin
        status_o = itp_pkg::ST_RANGE;
      end else begin
        value_o = signed_val & itp_pkg::type_mask(vtype_i[2:1]);
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/integer_token_parser.sv -----
// Integer token parser: takes text one character per cycle while ready is high and returns one integer per token.
// Depends on itp_pkg, itp_scan, itp_finish and integer_token_parser_macros.svh.
//
// Input stream: s_axis_tdata carries one ASCII character, s_axis_tuser the target type
// (0 i8, 1 u8, 2 i16, 3 u16, 4 i32, 5 u32, 6 i64, 7 u64) and s_axis_tlast marks the
// final character of a token. Output stream: one transaction per token, m_axis_tdata is
// the parsed value zero-extended from the type's width, m_axis_tuser the status
// (0 ok, 1 empty, 2 invalid char, 3 overflow, 4 out of range, 5 negative unsigned).
// The value is zero whenever the status is not ok.
// Throughput: one character per cycle while s_axis_tready is high, limited by the scanner update
// (shift-add multiply by the radix plus the overflow carry-out).
// A token's result passes the input register, the finished-token register and the output
// register in turn before it is presented.
// Reset clears the scanner to the start of a token and empties every stage.
// When the receiver stalls, the output register holds its result; characters that do not
// end a token keep flowing, and a final character waits only while both the finished-token
// register and the output register are occupied.
`default_nettype none

`include "integer_token_parser_macros.svh"

module integer_token_parser (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,   // [7:0] ch
  input  wire logic [2:0]   s_axis_tuser,   // [2:0] value_type
  input  wire logic         s_axis_tlast,   // last_char
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [63:0]       m_axis_tdata,   // [63:0] value
  output logic [2:0]        m_axis_tuser    // [2:0] status
);

  // Input register.
  logic       a_valid_q;
  logic [7:0] a_ch_q;
  logic [2:0] a_vtype_q;
  logic       a_last_q;

  // Finished-token register.
  logic              b_valid_q;
  itp_pkg::itp_tok_t b_tok_q;
  logic [2:0]        b_vtype_q;

  // Output register.
  logic                     out_valid_q;
  logic [itp_pkg::AccW-1:0] out_value_q;
  itp_pkg::status_e         out_status_q;

  logic                     a_adv, b_adv, b_free, in_fire;
  itp_pkg::itp_tok_t        scan_tok;
  logic [itp_pkg::AccW-1:0] fin_value;
  itp_pkg::status_e         fin_status;

  assign b_adv         = b_valid_q & (~out_valid_q | m_axis_tready);
  assign b_free        = ~b_valid_q | b_adv;
  assign a_adv         = a_valid_q & (~a_last_q | b_free);
  assign s_axis_tready = ~a_valid_q | a_adv;
  assign in_fire       = s_axis_tvalid & s_axis_tready;

  itp_scan u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (a_adv),
    .ch_i    (a_ch_q),
    .vtype_i (a_vtype_q),
    .last_i  (a_last_q),
    .tok_o   (scan_tok)
  );

  itp_finish u_finish (
    .tok_i    (b_tok_q),
    .vtype_i  (b_vtype_q),
    .value_o  (fin_value),
    .status_o (fin_status)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        a_valid_q <= 1'b1;
      end else if (a_adv) begin
        a_valid_q <= 1'b0;
      end
      if (a_adv && a_last_q) begin
        b_valid_q <= 1'b1;
      end else if (b_adv) begin
        b_valid_q <= 1'b0;
      end
      if (b_adv) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_ch_q    <= s_axis_tdata;
      a_vtype_q <= s_axis_tuser;
      a_last_q  <= s_axis_tlast;
    end
    if (a_adv && a_last_q) begin
      b_tok_q   <= scan_tok;
      b_vtype_q <= a_vtype_q;
    end
    if (b_adv) begin
      out_value_q  <= fin_value;
      out_status_q <= fin_status;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_value_q;
  assign m_axis_tuser  = out_status_q;

  // Any status other than ok carries a zero value.
  `ITP_ASSERT_IMP(a_err_value_zero, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser != itp_pkg::ST_OK), m_axis_tdata == '0)
  // Input stalls only when every stage behind it is full and the receiver holds off.
  `ITP_ASSERT_IMP(a_stall_cause, clk_i, rst_ni, !s_axis_tready, a_valid_q && a_last_q && b_valid_q && m_axis_tvalid && !m_axis_tready)
  // A finished token that advances reaches the output register on the next edge.
  `ITP_ASSERT_NXT(a_token_delivered, clk_i, rst_ni, b_adv, m_axis_tvalid)

endmodule

`default_nettype wire
